// ----- design/mmx_pkg.sv -----
// Shared types, widths and register codes for the quad X-frame motor mixer.
`default_nettype none

package mmx_pkg;

    localparam int LANES     = 4;
    localparam int CMD_W     = 32;
    localparam int COEF_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int MAG_W     = CMD_W;
    localparam int FULL_W    = MAG_W + COEF_W;
    localparam int PROD_W    = FULL_W - FRAC_W;
    localparam int TERM_W    = PROD_W + 1;
    localparam int PAIR_W    = TERM_W + 1;
    localparam int SUM_W     = PAIR_W + 1;
    localparam int SPEED_W   = 25;
    localparam int ROOT_W    = 24;
    localparam int RAD_W     = COEF_W + FRAC_W;
    localparam int REM_W     = ROOT_W + 3;
    localparam int DIGITS    = 2;
    localparam int SQ_STAGES = ROOT_W / DIGITS;
    localparam int CFG_IDX_W = 2;

    // lane order of the mixer terms
    localparam int LN_T = 0;
    localparam int LN_R = 1;
    localparam int LN_P = 2;
    localparam int LN_Y = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRUST_COEF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_COEF  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_COEF     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED_SQ = 2'd3;

    localparam logic [COEF_W-1:0] RST_THRUST_COEF  = 32'd234057;
    localparam logic [COEF_W-1:0] RST_TORQUE_COEF  = 32'd23406;
    localparam logic [COEF_W-1:0] RST_YAW_COEF     = 32'd1178705;
    localparam logic [COEF_W-1:0] RST_MAX_SPEED_SQ = 32'd519110656;

    typedef struct packed {
        logic signed [CMD_W-1:0] thrust_cmd;
        logic signed [CMD_W-1:0] roll_cmd;
        logic signed [CMD_W-1:0] pitch_cmd;
        logic signed [CMD_W-1:0] yaw_cmd;
    } t_in_word;

    typedef struct packed {
        logic [SPEED_W-1:0] motor1_speed;
        logic [SPEED_W-1:0] motor2_speed;
        logic [SPEED_W-1:0] motor3_speed;
        logic [SPEED_W-1:0] motor4_speed;
    } t_out_word;

    typedef struct packed {
        logic [COEF_W-1:0] thrust_coef;
        logic [COEF_W-1:0] torque_coef;
        logic [COEF_W-1:0] yaw_coef;
        logic [COEF_W-1:0] max_speed_sq;
    } t_cfg;

    typedef logic [LANES-1:0][TERM_W-1:0] t_terms;
    typedef logic [LANES-1:0][COEF_W-1:0] t_vals;
    typedef logic [LANES-1:0][ROOT_W-1:0] t_roots;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sq_lane;

    // one digit of the restoring square root
    function automatic t_sq_lane sq_digit(input t_sq_lane x);
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        t_sq_lane         y;
        rem_sh = {x.rem[REM_W-3:0], x.rad[RAD_W-1 -: 2]};
        trial  = {1'b0, x.root, 2'b01};
        y.rad  = {x.rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            y.rem  = rem_sh - trial;
            y.root = {x.root[ROOT_W-2:0], 1'b1};
        end else begin
            y.rem  = rem_sh;
            y.root = {x.root[ROOT_W-2:0], 1'b0};
        end
        return y;
    endfunction

endpackage

`default_nettype wire

// ----- design/mmx_mult.sv -----
// Command magnitudes, coefficient products and signed mixer terms.
`default_nettype none

module mmx_mult (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_vld,
    input  wire mmx_pkg::t_in_word  i_word,
    input  wire mmx_pkg::t_cfg      i_cfg,
    output logic                    o_vld,
    output mmx_pkg::t_terms         o_terms
);
    import mmx_pkg::*;

    logic [CMD_W-1:0]  cmd [LANES];
    logic [COEF_W-1:0] coef [LANES];

    logic [MAG_W-1:0]  r_mag [LANES];
    logic [LANES-1:0]  r_neg0;
    logic [PROD_W-1:0] r_prod [LANES];
    logic [LANES-1:0]  r_neg1;
    t_terms            r_terms;
    logic [2:0]        r_vld;

    logic [MAG_W-1:0]  n_mag [LANES];
    logic [PROD_W-1:0] n_prod [LANES];
    t_terms            n_terms;
    logic [FULL_W-1:0] full [LANES];

    always_comb begin
        cmd[LN_T]  = i_word.thrust_cmd;
        cmd[LN_R]  = i_word.roll_cmd;
        cmd[LN_P]  = i_word.pitch_cmd;
        cmd[LN_Y]  = i_word.yaw_cmd;
        coef[LN_T] = i_cfg.thrust_coef;
        coef[LN_R] = i_cfg.torque_coef;
        coef[LN_P] = i_cfg.torque_coef;
        coef[LN_Y] = i_cfg.yaw_coef;
        for (int l = 0; l < LANES; l++) begin
            n_mag[l]   = cmd[l][CMD_W-1] ? (~cmd[l] + 1'b1) : cmd[l];
            full[l]    = FULL_W'(r_mag[l]) * FULL_W'(coef[l]);
            n_prod[l]  = full[l][FULL_W-1:FRAC_W];
            n_terms[l] = r_neg1[l] ? (~{1'b0, r_prod[l]} + 1'b1) : {1'b0, r_prod[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < LANES; l++) begin
                r_mag[l]  <= n_mag[l];
                r_neg0[l] <= cmd[l][CMD_W-1];
                r_prod[l] <= n_prod[l];
                r_neg1[l] <= r_neg0[l];
            end
            r_terms <= n_terms;
        end
    end

    assign o_vld   = r_vld[2];
    assign o_terms = r_terms;

endmodule

`default_nettype wire

// ----- design/mmx_sum.sv -----
// Mixer sums for the four rotors, clamped to zero and to the squared speed limit.
`default_nettype none

module mmx_sum (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_vld,
    input  wire mmx_pkg::t_terms             i_terms,
    input  wire logic [mmx_pkg::COEF_W-1:0]  i_max,
    output logic                             o_vld,
    output mmx_pkg::t_vals                   o_vals
);
    import mmx_pkg::*;

    logic signed [PAIR_W-1:0] thr_ext, rol_ext, pit_ext, yaw_ext;
    logic signed [PAIR_W-1:0] n_pair [LANES];
    logic signed [PAIR_W-1:0] r_pair [LANES];
    logic signed [SUM_W-1:0]  a_ext, b_ext, c_ext, d_ext;
    logic signed [SUM_W-1:0]  sum [LANES];
    logic        [SUM_W-1:0]  max_ext;
    t_vals                    n_vals;
    t_vals                    r_vals;
    logic [1:0]               r_vld;

    always_comb begin
        thr_ext = {i_terms[LN_T][TERM_W-1], i_terms[LN_T]};
        rol_ext = {i_terms[LN_R][TERM_W-1], i_terms[LN_R]};
        pit_ext = {i_terms[LN_P][TERM_W-1], i_terms[LN_P]};
        yaw_ext = {i_terms[LN_Y][TERM_W-1], i_terms[LN_Y]};
        // a = T+R, b = T-R, c = Y-P, d = P+Y
        n_pair[0] = thr_ext + rol_ext;
        n_pair[1] = thr_ext - rol_ext;
        n_pair[2] = yaw_ext - pit_ext;
        n_pair[3] = pit_ext + yaw_ext;

        a_ext = {r_pair[0][PAIR_W-1], r_pair[0]};
        b_ext = {r_pair[1][PAIR_W-1], r_pair[1]};
        c_ext = {r_pair[2][PAIR_W-1], r_pair[2]};
        d_ext = {r_pair[3][PAIR_W-1], r_pair[3]};
        sum[0] = a_ext + c_ext;
        sum[1] = a_ext - c_ext;
        sum[2] = b_ext + d_ext;
        sum[3] = b_ext - d_ext;

        max_ext = SUM_W'(i_max);
        for (int l = 0; l < LANES; l++) begin
            priority if (sum[l][SUM_W-1]) begin
                n_vals[l] = '0;
            end else if (SUM_W'(sum[l]) > max_ext) begin
                n_vals[l] = i_max;
            end else begin
                n_vals[l] = sum[l][COEF_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < LANES; l++) begin
                r_pair[l] <= n_pair[l];
            end
            r_vals <= n_vals;
        end
    end

    assign o_vld  = r_vld[1];
    assign o_vals = r_vals;

endmodule

`default_nettype wire

// ----- design/mmx_sqrt.sv -----
// Pipelined floor square root, two root digits per stage, four lanes.
`default_nettype none

module mmx_sqrt (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_vld,
    input  wire mmx_pkg::t_vals   i_vals,
    output logic                  o_vld,
    output mmx_pkg::t_roots       o_roots
);
    import mmx_pkg::*;

    t_sq_lane [LANES-1:0]  r_lane [SQ_STAGES];
    t_sq_lane [LANES-1:0]  n_lane [SQ_STAGES];
    logic [SQ_STAGES-1:0]  r_vld;

    always_comb begin
        t_sq_lane x;
        for (int l = 0; l < LANES; l++) begin
            x.rad  = {i_vals[l], {FRAC_W{1'b0}}};
            x.rem  = '0;
            x.root = '0;
            for (int d = 0; d < DIGITS; d++) begin
                x = sq_digit(x);
            end
            n_lane[0][l] = x;
        end
        for (int s = 1; s < SQ_STAGES; s++) begin
            for (int l = 0; l < LANES; l++) begin
                x = r_lane[s-1][l];
                for (int d = 0; d < DIGITS; d++) begin
                    x = sq_digit(x);
                end
                n_lane[s][l] = x;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[SQ_STAGES-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_roots[l] = r_lane[SQ_STAGES-1][l].root;
        end
    end

    assign o_vld = r_vld[SQ_STAGES-1];

endmodule

`default_nettype wire

// ----- design/quad_x_motor_mixer.sv -----
// Top level of the quad X-frame motor mixer: registers, pipeline and checks.
//
//  channel | valid      | stall      | word
//  --------+------------+------------+-----------------------------------------
//  in      | i_in_valid | o_in_stall | i_in_word  (thrust, roll, pitch, yaw)
//  out     | o_out_valid| i_out_stall| o_out_word (motor1..motor4 speed)
//  cfg     | i_cfg_we   | -          | i_cfg_idx, i_cfg_data
//
// One word a cycle unless held: magnitude, product and sign are registered,
// then the mixer sums and clamp, then the square root at two digits a stage.
// The whole pipeline holds while the output word waits under i_out_stall.
// Reset clears the valid bits and loads the register defaults.
`default_nettype none

module quad_x_motor_mixer (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire mmx_pkg::t_in_word              i_in_word,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output mmx_pkg::t_out_word                  o_out_word,
    input  wire logic                           i_cfg_we,
    input  wire logic [mmx_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mmx_pkg::COEF_W-1:0]     i_cfg_data
);
    import mmx_pkg::*;

    t_cfg   r_cfg;
    logic   en;
    logic   mult_vld;
    t_terms mult_terms;
    logic   sum_vld;
    t_vals  sum_vals;
    t_roots roots;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thrust_coef  <= RST_THRUST_COEF;
            r_cfg.torque_coef  <= RST_TORQUE_COEF;
            r_cfg.yaw_coef     <= RST_YAW_COEF;
            r_cfg.max_speed_sq <= RST_MAX_SPEED_SQ;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRUST_COEF:  r_cfg.thrust_coef  <= i_cfg_data;
                CFG_TORQUE_COEF:  r_cfg.torque_coef  <= i_cfg_data;
                CFG_YAW_COEF:     r_cfg.yaw_coef     <= i_cfg_data;
                CFG_MAX_SPEED_SQ: r_cfg.max_speed_sq <= i_cfg_data;
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    // advance unless the output word is held
    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    mmx_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_in_valid),
        .i_word  (i_in_word),
        .i_cfg   (r_cfg),
        .o_vld   (mult_vld),
        .o_terms (mult_terms)
    );

    mmx_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (mult_vld),
        .i_terms (mult_terms),
        .i_max   (r_cfg.max_speed_sq),
        .o_vld   (sum_vld),
        .o_vals  (sum_vals)
    );

    mmx_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sum_vld),
        .i_vals  (sum_vals),
        .o_vld   (o_out_valid),
        .o_roots (roots)
    );

    assign o_out_word.motor1_speed = {1'b0, roots[0]};
    assign o_out_word.motor2_speed = {1'b0, roots[1]};
    assign o_out_word.motor3_speed = {1'b0, roots[2]};
    assign o_out_word.motor4_speed = {1'b0, roots[3]};

    a_stall_only_on_held_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held output word");

    a_clamp_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sum_vld |-> (sum_vals[0] <= r_cfg.max_speed_sq && sum_vals[1] <= r_cfg.max_speed_sq
                     && sum_vals[2] <= r_cfg.max_speed_sq
                     && sum_vals[3] <= r_cfg.max_speed_sq))
        else $error("clamped squared speed above limit");

    a_held_word_keeps_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(sum_vals) && $stable(sum_vld)))
        else $error("pipeline advanced while output word held");

endmodule

`default_nettype wire
